@@ rtl/xee_pkg.sv @@
package xee_pkg;

    // Depth of the raw group store, and a count width that covers its whole range.
    localparam int MAX_PENDING_DEF = 32;
    localparam int PEND_CNT_W      = 6;

    localparam logic [31:0] EXP_LIMIT_RST = 32'd100000;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;

    localparam logic [63:0] UTF_LIM1 = 64'h80;
    localparam logic [63:0] UTF_LIM2 = 64'h800;
    localparam logic [63:0] UTF_LIM3 = 64'h10000;
    localparam logic [63:0] UTF_LIM4 = 64'h110000;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_LEAD4 = 8'hF0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [7:0]  UTF_MASK  = 8'h3F;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       end_of_text;
        logic       new_document;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last_of_run;
        logic       text_done;
        logic       limit_error;
    } t_out_word;

    // One item's results: a literal flush of the group store, then direct bytes.
    typedef struct packed {
        logic [PEND_CNT_W-1:0] fl_cnt;
        logic [3:0][7:0]       dir;
        logic [2:0]            dir_cnt;
        logic                  eot;
        logic                  err;
    } t_job;

    typedef struct packed {
        logic                  en;
        logic [PEND_CNT_W-1:0] addr;
        logic [7:0]            data;
    } t_pend_wr;

endpackage

@@ rtl/xee_if.sv @@
interface xee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;
    logic       new_document;

    modport source (output valid, text_byte, has_byte, end_of_text, new_document,
                    input ready);
    modport sink (input valid, text_byte, has_byte, end_of_text, new_document,
                  output ready);
endinterface

interface xee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last_of_run;
    logic       text_done;
    logic       limit_error;

    modport source (output valid, out_byte, out_valid, last_of_run, text_done,
                    limit_error, input ready);
    modport sink (input valid, out_byte, out_valid, last_of_run, text_done,
                  limit_error, output ready);
endinterface

interface xee_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ rtl/xee_parse.sv @@
module xee_parse import xee_pkg::*; #(
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_in_word    i_word,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_job_vld,
    output t_job        o_job,
    output t_pend_wr    o_wr
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_START, PH_HASH, PH_NUM, PH_NAME, PH_STREAM
    } t_phase;

    logic                  r_in_grp, n_in_grp;
    t_phase                r_phase, n_phase;
    logic [PEND_CNT_W-1:0] r_pend, n_pend;
    logic [63:0]           r_cp, n_cp;
    logic                  r_hex, n_hex;
    logic [31:0]           r_cnt, n_cnt;
    logic                  r_err, n_err;
    logic [31:0]           r_max;
    logic [3:0][7:0]       r_nm;

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= "0" && b <= "9") v = 4'(b - "0");
        else if (b >= "a" && b <= "f") v = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") v = 4'(b - "A" + 8'd10);
        return v;
    endfunction

    logic [7:0]  b;
    logic [8:0]  dgt;
    logic [63:0] dgt_x;
    logic        leave, name_hit;
    logic [7:0]  name_ch;

    assign b     = i_word.text_byte;
    assign dgt   = {1'b0, b} - 9'd48;
    assign dgt_x = {{55{dgt[8]}}, dgt};

    // Name lookup uses the first four bytes after '&' plus the exact group length.
    always_comb begin
        name_hit = 1'b1;
        name_ch  = "<";
        if (r_pend == PEND_CNT_W'(3) && r_nm[0] == "l" && r_nm[1] == "t") begin
            name_ch = "<";
        end else if (r_pend == PEND_CNT_W'(3) && r_nm[0] == "g" && r_nm[1] == "t") begin
            name_ch = ">";
        end else if (r_pend == PEND_CNT_W'(4) && r_nm[0] == "a" && r_nm[1] == "m"
                     && r_nm[2] == "p") begin
            name_ch = "&";
        end else if (r_pend == PEND_CNT_W'(5) && r_nm[0] == "a" && r_nm[1] == "p"
                     && r_nm[2] == "o" && r_nm[3] == "s") begin
            name_ch = "'";
        end else if (r_pend == PEND_CNT_W'(5) && r_nm[0] == "q" && r_nm[1] == "u"
                     && r_nm[2] == "o" && r_nm[3] == "t") begin
            name_ch = "\"";
        end else begin
            name_hit = 1'b0;
        end
    end

    always_comb begin
        n_in_grp = r_in_grp;
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_cp     = r_cp;
        n_hex    = r_hex;
        n_cnt    = i_word.new_document ? 32'd0 : r_cnt;
        n_err    = i_word.new_document ? 1'b0 : r_err;
        o_job    = '0;
        o_wr     = '0;
        leave    = 1'b0;

        if (i_acc && i_word.has_byte) begin
            if (n_err) begin
                leave = 1'b1;
            end else if (!r_in_grp) begin
                if (b == CH_AMP) begin
                    n_in_grp = 1'b1;
                    n_phase  = PH_START;
                    n_pend   = PEND_CNT_W'(1);
                end else begin
                    o_job.dir[0]  = b;
                    o_job.dir_cnt = 3'd1;
                end
            end else if (b == CH_SEMI) begin
                if (n_cnt != 32'hFFFF_FFFF) n_cnt = n_cnt + 32'd1;
                leave = 1'b1;
                if (n_cnt > r_max) begin
                    n_err = 1'b1;
                end else if (r_phase == PH_NUM) begin
                    if (r_cp < UTF_LIM1) begin
                        o_job.dir[0]  = r_cp[7:0];
                        o_job.dir_cnt = 3'd1;
                    end else if (r_cp < UTF_LIM2) begin
                        o_job.dir[0]  = UTF_LEAD2 | {3'd0, r_cp[10:6]};
                        o_job.dir[1]  = UTF_CONT | {2'd0, r_cp[5:0]};
                        o_job.dir_cnt = 3'd2;
                    end else if (r_cp < UTF_LIM3) begin
                        o_job.dir[0]  = UTF_LEAD3 | {4'd0, r_cp[15:12]};
                        o_job.dir[1]  = UTF_CONT | {2'd0, r_cp[11:6]};
                        o_job.dir[2]  = UTF_CONT | {2'd0, r_cp[5:0]};
                        o_job.dir_cnt = 3'd3;
                    end else if (r_cp < UTF_LIM4) begin
                        o_job.dir[0]  = UTF_LEAD4 | {5'd0, r_cp[20:18]};
                        o_job.dir[1]  = UTF_CONT | (r_cp[19:12] & UTF_MASK);
                        o_job.dir[2]  = UTF_CONT | {2'd0, r_cp[11:6]};
                        o_job.dir[3]  = UTF_CONT | {2'd0, r_cp[5:0]};
                        o_job.dir_cnt = 3'd4;
                    end
                end else if (r_phase == PH_STREAM) begin
                    o_job.dir[0]  = CH_SEMI;
                    o_job.dir_cnt = 3'd1;
                end else if (r_phase == PH_NAME && name_hit) begin
                    o_job.dir[0]  = name_ch;
                    o_job.dir_cnt = 3'd1;
                end else begin
                    o_job.fl_cnt  = r_pend;
                    o_job.dir[0]  = CH_SEMI;
                    o_job.dir_cnt = 3'd1;
                end
            end else if (r_phase == PH_STREAM) begin
                o_job.dir[0]  = b;
                o_job.dir_cnt = 3'd1;
            end else if (r_pend >= PEND_CNT_W'(MAX_PENDING)) begin
                // store full: spill literally; an overlong name keeps streaming
                o_job.fl_cnt  = r_pend;
                o_job.dir[0]  = b;
                o_job.dir_cnt = 3'd1;
                if (r_phase == PH_NAME) begin
                    n_phase = PH_STREAM;
                    n_pend  = '0;
                end else begin
                    leave = 1'b1;
                end
            end else begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_pend;
                o_wr.data = b;
                n_pend    = r_pend + PEND_CNT_W'(1);
                case (r_phase)
                    PH_START: n_phase = (b == CH_HASH) ? PH_HASH : PH_NAME;
                    PH_HASH: begin
                        n_phase = PH_NUM;
                        if (b == "x" || b == "X") begin
                            n_hex = 1'b1;
                            n_cp  = '0;
                        end else begin
                            n_hex = 1'b0;
                            n_cp  = dgt_x;
                        end
                    end
                    PH_NUM: begin
                        if (r_hex) n_cp = {r_cp[59:0], hex_val(b)};
                        else n_cp = {r_cp[60:0], 3'd0} + {r_cp[62:0], 1'b0} + dgt_x;
                    end
                    default: ;
                endcase
            end
        end

        if (leave) begin
            n_in_grp = 1'b0;
            n_phase  = PH_IDLE;
            n_pend   = '0;
            n_cp     = '0;
            n_hex    = 1'b0;
        end

        if (i_acc && i_word.end_of_text && n_in_grp) begin
            if (!n_err && n_phase != PH_STREAM) o_job.fl_cnt = n_pend;
            n_in_grp = 1'b0;
            n_phase  = PH_IDLE;
            n_pend   = '0;
            n_cp     = '0;
            n_hex    = 1'b0;
        end

        o_job.eot = i_word.end_of_text;
        o_job.err = n_err;
        o_job_vld = i_acc && (o_job.fl_cnt != '0 || o_job.dir_cnt != 3'd0
                              || i_word.end_of_text);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_grp <= 1'b0;
            r_phase  <= PH_IDLE;
            r_pend   <= '0;
            r_cp     <= '0;
            r_hex    <= 1'b0;
            r_cnt    <= '0;
            r_err    <= 1'b0;
            r_max    <= EXP_LIMIT_RST;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_data;
            if (i_acc) begin
                r_in_grp <= n_in_grp;
                r_phase  <= n_phase;
                r_pend   <= n_pend;
                r_cp     <= n_cp;
                r_hex    <= n_hex;
                r_cnt    <= n_cnt;
                r_err    <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr.en && r_pend >= PEND_CNT_W'(1) && r_pend <= PEND_CNT_W'(4)) begin
            r_nm[2'(r_pend - PEND_CNT_W'(1))] <= b;
        end
    end

endmodule

@@ rtl/xee_emit.sv @@
module xee_emit import xee_pkg::*; #(
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_job      i_job,
    input  t_pend_wr  i_wr,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out,
    output logic      o_take_ok
);

    localparam int AW = $clog2(MAX_PENDING);

    logic [7:0]            r_mem [MAX_PENDING];
    logic [7:0]            r_rd_data;
    logic                  r_busy;
    logic [PEND_CNT_W-1:0] r_fl_cnt, r_fl_idx;
    logic [3:0][7:0]       r_dir;
    logic [2:0]            r_dir_cnt;
    logic                  r_eot, r_err;
    logic                  r_o_vld;
    t_out_word             r_o;

    logic          in_fl, is_last, advance, rd_en;
    logic [7:0]    cur_byte;
    logic [AW-1:0] rd_addr;

    always_comb begin
        in_fl = r_fl_idx < r_fl_cnt;
        // entry 0 of a group is always '&', so it never needs a read
        if (in_fl) cur_byte = (r_fl_idx == '0) ? CH_AMP : r_rd_data;
        else cur_byte = (r_dir_cnt != 3'd0) ? r_dir[0] : 8'h00;
        if (in_fl) is_last = (r_fl_idx + PEND_CNT_W'(1) == r_fl_cnt) && r_dir_cnt == 3'd0;
        else is_last = r_dir_cnt <= 3'd1;
        advance   = r_busy && (!r_o_vld || i_out_ready);
        o_take_ok = !r_busy || (advance && is_last);
        rd_en     = (i_load && i_job.fl_cnt != '0) || (advance && in_fl);
        rd_addr   = i_load ? AW'(1) : AW'(r_fl_idx + PEND_CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        if (rd_en) begin
            r_rd_data <= (i_wr.en && i_wr.addr[AW-1:0] == rd_addr) ? i_wr.data
                                                                  : r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_o_vld         <= 1'b1;
                r_o.out_byte    <= cur_byte;
                r_o.out_valid   <= in_fl || r_dir_cnt != 3'd0;
                r_o.last_of_run <= is_last;
                r_o.text_done   <= is_last && r_eot;
                r_o.limit_error <= r_err;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            // a new job takes over in the cycle the last word of the old one leaves
            if (i_load) begin
                r_busy    <= 1'b1;
                r_fl_cnt  <= i_job.fl_cnt;
                r_fl_idx  <= '0;
                r_dir     <= i_job.dir;
                r_dir_cnt <= i_job.dir_cnt;
                r_eot     <= i_job.eot;
                r_err     <= i_job.err;
            end else if (advance) begin
                if (in_fl) begin
                    r_fl_idx <= r_fl_idx + PEND_CNT_W'(1);
                end else if (r_dir_cnt != 3'd0) begin
                    r_dir     <= r_dir >> 8;
                    r_dir_cnt <= r_dir_cnt - 3'd1;
                end
                if (is_last) r_busy <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out       = r_o;

endmodule

@@ rtl/xml_entity_expander.sv @@
// XML entity expander. While the output accepts words it takes one text word per
// cycle and returns expanded bytes one word per cycle, each registered in the
// result sequencer, then in the output register. A word that yields one result
// (plain text, a closing ';' of a recognized name) keeps that rate. A word that
// yields several (a numeric reference of up to four UTF-8 bytes, or a literal flush
// of up to MAX_PENDING raw group bytes plus one) holds input ready low while the
// sequencer walks the raw store one entry per cycle. No start-up sweep after reset.
module xml_entity_expander import xee_pkg::*; #(
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    xee_in_if.sink   i_in,
    xee_out_if.source o_out,
    xee_cfg_if.sink  i_cfg
);

    t_in_word  in_word;
    t_job      job;
    t_pend_wr  pend_wr;
    t_out_word out_word;
    logic      acc, job_vld, take_ok, out_vld;

    assign in_word = '{text_byte:    i_in.text_byte,
                       has_byte:     i_in.has_byte,
                       end_of_text:  i_in.end_of_text,
                       new_document: i_in.new_document};
    assign i_in.ready = take_ok;
    assign acc        = i_in.valid && take_ok;
    assign i_cfg.ready = 1'b1;

    xee_parse #(.MAX_PENDING(MAX_PENDING)) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_word     (in_word),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_job_vld  (job_vld),
        .o_job      (job),
        .o_wr       (pend_wr)
    );

    xee_emit #(.MAX_PENDING(MAX_PENDING)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (job_vld),
        .i_job       (job),
        .i_wr        (pend_wr),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_vld),
        .o_out       (out_word),
        .o_take_ok   (take_ok)
    );

    assign o_out.valid       = out_vld;
    assign o_out.out_byte    = out_word.out_byte;
    assign o_out.out_valid   = out_word.out_valid;
    assign o_out.last_of_run = out_word.last_of_run;
    assign o_out.text_done   = out_word.text_done;
    assign o_out.limit_error = out_word.limit_error;

endmodule

@@ rtl/xee_chk.sv @@
module xee_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_vld,
    input logic       i_out_rdy,
    input logic [7:0] i_out_byte,
    input logic       i_out_bvld,
    input logic       i_out_last,
    input logic       i_out_done,
    input logic       i_out_err
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_out_byte)
            && $stable(i_out_bvld) && $stable(i_out_last) && $stable(i_out_done)
            && $stable(i_out_err))
        else $error("output word changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_vld)
        else $error("output valid after reset");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && i_out_done |-> i_out_last)
        else $error("text end not on last word of run");

    // a word without a byte is only the end-of-text marker
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_bvld |-> i_out_last && i_out_done && i_out_byte == 8'h00)
        else $error("empty word that is not an end marker");

endmodule

bind xml_entity_expander xee_chk u_xee_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_vld  (o_out.valid),
    .i_out_rdy  (o_out.ready),
    .i_out_byte (o_out.out_byte),
    .i_out_bvld (o_out.out_valid),
    .i_out_last (o_out.last_of_run),
    .i_out_done (o_out.text_done),
    .i_out_err  (o_out.limit_error)
);

@@ verif/xml_entity_expander_tb.sv @@
module xml_entity_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xee_pkg::*;

    localparam int          DEPTH       = MAX_PENDING_DEF;
    localparam int unsigned HOLD_LEN    = 300;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASE_WORDS = 25;

    typedef enum logic [2:0] {
        GP_IDLE,
        GP_AMP,
        GP_HASH,
        GP_DIGITS,
        GP_NAME,
        GP_STREAM
    } t_grp_phase;

    typedef struct packed {
        t_in_word   word;
        logic [3:0] gap;
    } t_text_item;

    logic i_clk;
    logic i_rst_n;

    xee_in_if  text_in ();
    xee_out_if text_out ();
    xee_cfg_if limit_cfg ();

    xml_entity_expander DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_in),
        .o_out   (text_out),
        .i_cfg   (limit_cfg)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // stimulus and expectation stores
    t_text_item  text_q[$];
    t_out_word   exp_q[$];
    logic [7:0]  run_q[$];
    logic [7:0]  seg_q[$];

    int unsigned pushed_cnt = 0;
    int unsigned taken_cnt  = 0;
    int unsigned fail_cnt   = 0;
    int unsigned stall_cnt  = 0;
    int unsigned tx_wait    = 0;
    int unsigned rx_wait    = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_reqs  = 0;
    int unsigned hold_done  = 0;
    bit          no_idle    = 0;

    bit in_acc  = 0;
    bit out_acc = 0;
    bit cfg_acc = 0;

    // expander state
    bit          in_grp    = 0;
    t_grp_phase  phase     = GP_IDLE;
    logic [7:0]  raw_grp [0:DEPTH-1];
    int unsigned raw_cnt   = 0;
    logic [63:0] cp        = '0;
    bit          hex_form  = 0;
    logic [31:0] grp_cnt   = '0;
    bit          lim_err   = 0;
    logic [31:0] max_limit = EXP_LIMIT_RST;

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic put_run(input logic [7:0] b);
        run_q.insert(run_q.size(), b);
    endtask

    task automatic put_seg(input logic [7:0] b);
        seg_q.insert(seg_q.size(), b);
    endtask

    task automatic put_exp(input t_out_word w);
        exp_q.insert(exp_q.size(), w);
    endtask

    // ---------------------------------------------------------------
    // expansion predictor
    // ---------------------------------------------------------------
    task automatic drop_group();
        in_grp   = 0;
        phase    = GP_IDLE;
        raw_cnt  = 0;
        cp       = '0;
        hex_form = 0;
    endtask

    task automatic dump_raw();
        for (int i = 0; i < raw_cnt; i++) put_run(raw_grp[i]);
        raw_cnt = 0;
    endtask

    function automatic logic [63:0] hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return {56'd0, b - "0"};
        if (b >= "a" && b <= "f") return {56'd0, b - "a"} + 64'd10;
        if (b >= "A" && b <= "F") return {56'd0, b - "A"} + 64'd10;
        return 64'd0;
    endfunction

    // 0 when the raw group is no known name
    function automatic logic [7:0] entity_char();
        if (raw_cnt == 3 && raw_grp[1] == "l" && raw_grp[2] == "t") return "<";
        if (raw_cnt == 3 && raw_grp[1] == "g" && raw_grp[2] == "t") return ">";
        if (raw_cnt == 4 && raw_grp[1] == "a" && raw_grp[2] == "m" && raw_grp[3] == "p")
            return "&";
        if (raw_cnt == 5 && raw_grp[1] == "a" && raw_grp[2] == "p" && raw_grp[3] == "o"
                && raw_grp[4] == "s")
            return "'";
        if (raw_cnt == 5 && raw_grp[1] == "q" && raw_grp[2] == "u" && raw_grp[3] == "o"
                && raw_grp[4] == "t")
            return "\"";
        return 8'h00;
    endfunction

    task automatic put_utf8(input logic [63:0] v);
        if (v < UTF_LIM1) begin
            put_run(v[7:0]);
        end else if (v < UTF_LIM2) begin
            put_run(UTF_LEAD2 | v[13:6]);
            put_run(UTF_CONT | {2'b00, v[5:0]});
        end else if (v < UTF_LIM3) begin
            put_run(UTF_LEAD3 | v[19:12]);
            put_run(UTF_CONT | {2'b00, v[11:6]});
            put_run(UTF_CONT | {2'b00, v[5:0]});
        end else if (v < UTF_LIM4) begin
            put_run(UTF_LEAD4 | v[25:18]);
            put_run(UTF_CONT | {2'b00, v[17:12]});
            put_run(UTF_CONT | {2'b00, v[11:6]});
            put_run(UTF_CONT | {2'b00, v[5:0]});
        end
        // out of range code points give nothing
    endtask

    task automatic close_group();
        logic [7:0] ch;
        if (grp_cnt != 32'hFFFF_FFFF) grp_cnt = grp_cnt + 32'd1;
        if (grp_cnt > max_limit) begin
            lim_err = 1;
            drop_group();
            return;
        end
        ch = entity_char();
        if (phase == GP_DIGITS) begin
            put_utf8(cp);
        end else if (phase == GP_STREAM) begin
            put_run(CH_SEMI);
        end else if (phase == GP_NAME && ch != 8'h00) begin
            put_run(ch);
        end else begin
            dump_raw();
            put_run(CH_SEMI);
        end
        drop_group();
    endtask

    task automatic take_byte(input logic [7:0] b);
        if (lim_err) begin
            drop_group();
            return;
        end
        if (!in_grp) begin
            if (b == CH_AMP) begin
                in_grp     = 1;
                phase      = GP_AMP;
                raw_grp[0] = b;
                raw_cnt    = 1;
            end else begin
                put_run(b);
            end
            return;
        end
        if (b == CH_SEMI) begin
            close_group();
            return;
        end
        if (phase == GP_STREAM) begin
            put_run(b);
            return;
        end
        // store full: names keep streaming, numeric refs give up
        if (raw_cnt >= DEPTH) begin
            dump_raw();
            put_run(b);
            if (phase == GP_NAME) phase = GP_STREAM;
            else drop_group();
            return;
        end
        raw_grp[raw_cnt] = b;
        raw_cnt = raw_cnt + 1;
        case (phase)
            GP_AMP: begin
                phase = (b == CH_HASH) ? GP_HASH : GP_NAME;
            end
            GP_HASH: begin
                if (b == "x" || b == "X") begin
                    hex_form = 1;
                    cp       = '0;
                end else begin
                    hex_form = 0;
                    cp       = {56'd0, b} - 64'h30;
                end
                phase = GP_DIGITS;
            end
            GP_DIGITS: begin
                if (hex_form) cp = cp * 64'd16 + hex_nibble(b);
                else cp = cp * 64'd10 + ({56'd0, b} - 64'h30);
            end
            default: ;
        endcase
    endtask

    task automatic expand_word(input t_in_word w);
        t_out_word   r;
        int unsigned n;
        if (w.new_document) begin
            grp_cnt = '0;
            lim_err = 0;
        end
        if (w.has_byte) take_byte(w.text_byte);
        if (w.end_of_text && in_grp) begin
            if (!lim_err && phase != GP_STREAM) dump_raw();
            drop_group();
        end
        n = run_q.size();
        if (w.end_of_text && n == 0) begin
            r             = '0;
            r.last_of_run = 1'b1;
            r.text_done   = 1'b1;
            r.limit_error = lim_err;
            put_exp(r);
        end
        for (int i = 0; i < n; i++) begin
            r.out_byte    = run_q[i];
            r.out_valid   = 1'b1;
            r.last_of_run = (i == n - 1);
            r.text_done   = (i == n - 1) && w.end_of_text;
            r.limit_error = lim_err;
            put_exp(r);
        end
        run_q.delete();
    endtask

    task automatic flag_field(input string fld, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
            fail_cnt++;
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: sample at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_in_word  wi;
        t_out_word got;
        t_out_word want;
        bit        moved;
        in_acc  <= text_in.valid && text_in.ready;
        out_acc <= text_out.valid && text_out.ready;
        cfg_acc <= limit_cfg.valid && limit_cfg.ready;
        if (i_rst_n) begin
            moved = (text_in.valid && text_in.ready) || (text_out.valid && text_out.ready)
                    || (limit_cfg.valid && limit_cfg.ready);
            stall_cnt = moved ? 0 : stall_cnt + 1;
            if (limit_cfg.valid && limit_cfg.ready) max_limit = limit_cfg.data;
            if (text_in.valid && text_in.ready) begin
                wi.text_byte    = text_in.text_byte;
                wi.has_byte     = text_in.has_byte;
                wi.end_of_text  = text_in.end_of_text;
                wi.new_document = text_in.new_document;
                expand_word(wi);
                taken_cnt++;
            end
            if (text_out.valid && text_out.ready) begin
                got.out_byte    = text_out.out_byte;
                got.out_valid   = text_out.out_valid;
                got.last_of_run = text_out.last_of_run;
                got.text_done   = text_out.text_done;
                got.limit_error = text_out.limit_error;
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0h",
                             $time, got);
                    fail_cnt++;
                end else begin
                    want = exp_q.pop_front();
                    flag_field("out_byte", want.out_byte, got.out_byte);
                    flag_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
                    flag_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
                    flag_field("text_done", 8'(want.text_done), 8'(got.text_done));
                    flag_field("limit_error", 8'(want.limit_error), 8'(got.limit_error));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sender: drives at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : tx_pace
        t_text_item nxt;
        if (!i_rst_n) begin
            text_in.valid <= 1'b0;
        end else if (!text_in.valid || in_acc) begin
            if (text_q.size() != 0) nxt = text_q[0];
            if (text_q.size() != 0 && tx_wait >= nxt.gap) begin
                nxt = text_q.pop_front();
                text_in.valid        <= 1'b1;
                text_in.text_byte    <= nxt.word.text_byte;
                text_in.has_byte     <= nxt.word.has_byte;
                text_in.end_of_text  <= nxt.word.end_of_text;
                text_in.new_document <= nxt.word.new_document;
                tx_wait <= 0;
            end else begin
                text_in.valid <= 1'b0;
                if (text_q.size() != 0) tx_wait <= tx_wait + 1;
            end
        end
    end

    // receiver: random back-pressure plus requested long hold-offs
    always @(negedge i_clk) begin : rx_pace
        int unsigned w;
        if (!i_rst_n) begin
            text_out.ready <= 1'b0;
        end else if (hold_left != 0) begin
            text_out.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_reqs) begin
            text_out.ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= hold_done + 1;
        end else if (out_acc || !text_out.ready) begin
            w = out_acc ? draw_gap() : rx_wait;
            if (w == 0) begin
                text_out.ready <= 1'b1;
            end else begin
                text_out.ready <= 1'b0;
                rx_wait <= w - 1;
            end
        end
    end

    initial begin : watchdog
        while (stall_cnt < STALL_LIMIT) @(posedge i_clk);
        $display("xml_entity_expander_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input bit has, input bit eot, input bit nd);
        t_text_item it;
        it.word.text_byte    = b;
        it.word.has_byte     = has;
        it.word.end_of_text  = eot;
        it.word.new_document = nd;
        it.gap               = 4'(draw_gap());
        text_q.insert(text_q.size(), it);
        pushed_cnt++;
    endtask

    task automatic send_str(input string s, input bit eot);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, eot && (i == s.len() - 1), 1'b0);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) put_seg(s[i]);
    endtask

    task automatic add_hex(input logic [63:0] v);
        string      s;
        logic [7:0] c;
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            put_seg(c);
        end
    endtask

    // spread code points over every UTF-8 length and past the top
    function automatic logic [63:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 32'h7F));
            1: return 64'($urandom_range(32'h80, 32'h7FF));
            2: return 64'($urandom_range(32'h800, 32'hFFFF));
            3: return 64'($urandom_range(32'h10000, 32'h10FFFF));
            4: return 64'($urandom_range(32'h110000, 32'hFFFF_FFFF));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_segment();
        string      nm;
        string      hex_set;
        logic [7:0] c;
        int unsigned n;
        int unsigned mut;
        hex_set = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 9))
            0, 1: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    c = 8'($urandom);
                    put_seg(c);
                end
            end
            2, 3: begin
                case ($urandom_range(0, 4))
                    0: nm = "lt";
                    1: nm = "gt";
                    2: nm = "amp";
                    3: nm = "apos";
                    default: nm = "quot";
                endcase
                mut = $urandom_range(0, 5);
                put_seg(CH_AMP);
                for (int i = 0; i < nm.len(); i++) begin
                    if (mut == 0 && i == nm.len() - 1) break;
                    c = nm[i];
                    if (mut == 1 && i == 0) c = 8'("a" + $urandom_range(0, 25));
                    put_seg(c);
                end
                put_seg(CH_SEMI);
            end
            4: begin
                add_str("&#");
                if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(20, 36);
                    repeat (n) begin
                        c = 8'("0" + $urandom_range(0, 9));
                        put_seg(c);
                    end
                end else begin
                    add_str($sformatf("%0d", pick_code()));
                end
                if ($urandom_range(0, 5) == 0) begin
                    c = 8'($urandom);
                    put_seg(c);
                end
                if ($urandom_range(0, 7) != 0) put_seg(CH_SEMI);
            end
            5: begin
                put_seg(CH_AMP);
                put_seg(CH_HASH);
                c = ($urandom_range(0, 1) == 1) ? "x" : "X";
                put_seg(c);
                mut = $urandom_range(0, 9);
                if (mut == 1) begin
                    n = $urandom_range(20, 36);
                    repeat (n) put_seg(hex_set[$urandom_range(0, 21)]);
                end else if (mut != 0) begin
                    repeat ($urandom_range(0, 2)) put_seg("0");
                    add_hex(pick_code());
                end
                if ($urandom_range(0, 5) == 0) begin
                    c = 8'($urandom);
                    put_seg(c);
                end
                if ($urandom_range(0, 7) != 0) put_seg(CH_SEMI);
            end
            6: begin
                // long names around the store depth
                put_seg(CH_AMP);
                n = $urandom_range(DEPTH - 6, DEPTH + 8);
                repeat (n) begin
                    c = 8'("a" + $urandom_range(0, 25));
                    put_seg(c);
                end
                if ($urandom_range(0, 1) == 1) put_seg(CH_SEMI);
            end
            7: begin
                put_seg(CH_AMP);
                repeat ($urandom_range(0, 3)) begin
                    c = 8'("a" + $urandom_range(0, 25));
                    put_seg(c);
                end
            end
            8: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: c = CH_AMP;
                        1: c = CH_SEMI;
                        2: c = CH_HASH;
                        default: c = 8'($urandom);
                    endcase
                    put_seg(c);
                end
            end
            default: begin
                put_seg(CH_AMP);
                if ($urandom_range(0, 1) == 1) put_seg(CH_HASH);
                put_seg(CH_SEMI);
            end
        endcase
    endtask

    task automatic gen_text();
        int unsigned n_seg;
        int unsigned last;
        bit          nd;
        bit          bare;
        seg_q.delete();
        n_seg = $urandom_range(1, 5);
        repeat (n_seg) add_segment();
        nd   = ($urandom_range(0, 2) == 0);
        bare = ($urandom_range(0, 3) == 0);
        last = seg_q.size() - 1;
        for (int i = 0; i <= last; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            send_item(seg_q[i], 1'b1, (i == last) && !bare, nd && (i == 0));
        end
        if (bare) send_item(8'($urandom), 1'b0, 1'b1, 1'($urandom_range(0, 1)));
    endtask

    // wait for every word taken and every result back, then let stragglers settle
    task automatic drain();
        do @(negedge i_clk); while (taken_cnt != pushed_cnt || exp_q.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned mark;
        mark = pushed_cnt;
        while (pushed_cnt - mark < n) gen_text();
        drain();
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(negedge i_clk);
        limit_cfg.valid <= 1'b1;
        limit_cfg.data  <= v;
        do @(negedge i_clk); while (!cfg_acc);
        limit_cfg.valid <= 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n              = 1'b0;
        text_in.valid        = 1'b0;
        text_in.text_byte    = '0;
        text_in.has_byte     = 1'b0;
        text_in.end_of_text  = 1'b0;
        text_in.new_document = 1'b0;
        text_out.ready       = 1'b0;
        limit_cfg.valid      = 1'b0;
        limit_cfg.data       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, amp name, empty numeric forms, a 2-byte code,
        // a non-digit in decimal, a no-result step, an open group flushed at end,
        // and a bare end marker
        send_item(8'h00, 1'b1, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);
        send_str("&amp;", 1'b0);
        send_str("&#x;", 1'b0);
        send_str("&#;", 1'b0);
        send_str("&#xE9;", 1'b0);
        send_str("&#2a;", 1'b0);
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        send_str("&q", 1'b1);
        send_item(8'hA5, 1'b0, 1'b1, 1'b0);
        drain();

        write_limit(32'hFFFF_FFFF);
        hold_reqs = hold_reqs + 1;
        run_phase(PHASE_WORDS);

        write_limit(32'd0);
        run_phase(PHASE_WORDS);

        write_limit(32'd2);
        no_idle = 1;
        run_phase(PHASE_WORDS);
        no_idle = 0;

        write_limit($urandom_range(1, 6));
        run_phase(PHASE_WORDS);

        write_limit($urandom);
        run_phase(PHASE_WORDS);

        if (fail_cnt == 0) begin
            $display("xml_entity_expander_tb: clean");
        end else begin
            $display("xml_entity_expander_tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/xee_pkg.sv
rtl/xee_if.sv
rtl/xee_parse.sv
rtl/xee_emit.sv
rtl/xml_entity_expander.sv
rtl/xee_chk.sv
verif/xml_entity_expander_tb.sv
